FILE: hw/rtl/cda_pkg.sv
// Shared types, constants and month-length helpers for the calendar date block.
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_YEAR_BITS  = 16;

  localparam int RESET_YEAR = 2000;

  localparam logic [11:0] DAYS_PER_QUAD   = 12'd1461;
  localparam logic [11:0] MONTHS_PER_YEAR = 12'd12;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_NOV = 4'd10;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  localparam logic [4:0] FIRST_DAY = 5'd1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_DAYS   = 2'd1,
    KIND_MONTHS = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BUMP,
    ST_WALK,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic start;
    logic div_step;
    logic bump;
    logic walk;
    logic clamp;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_fits;
    logic out_free;
  } sts_t;

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [4:0] len);
    logic [4:0] r;
    r = d;
    if (r < FIRST_DAY) begin
      r = FIRST_DAY;
    end
    if (r > len) begin
      r = len;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/calendar_date_advance.sv
// Top level of the calendar date block: controller plus datapath.
// The block holds one date (day, month 0 to 11, year) and takes one word per
// item on the input channel: kind 0 loads a date, kind 1 adds count days,
// kind 2 adds count months, kind 3 leaves the date as it is. Every item
// returns one word on the output channel with the new date, the leap flag
// and a flag that the year wrapped past its maximum during that item.
// A load or a kind 3 word goes straight to the done state, which emits it.
// An add first forms the quotient by 1461 days or by 12 months with a
// reciprocal multiply, then adds it to the year. Days then walk the remainder
// one month per cycle, over at most 48 month boundaries, and end with a step
// that adds the days left; months take one clamp step. The states run divide,
// bump, then walk for days or clamp for months, and then done. Items are worked
// one at a time; the next word is taken once the controller is back in idle,
// which it enters in the same cycle that the result appears.
// If the receiver stalls, the finished date waits in the datapath until the
// output register frees, and no further input is taken until then.
// Reset sets the date to January 1, 2000 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_advance #(
  parameter int COUNT_BITS = cda_pkg::DEF_COUNT_BITS,
  parameter int YEAR_BITS  = cda_pkg::DEF_YEAR_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [COUNT_BITS-1:0] count_i,
  input  wire logic [4:0]            load_day_i,
  input  wire logic [3:0]            load_month_i,
  input  wire logic [15:0]           load_year_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [4:0]                 day_o,
  output logic [3:0]                 month_o,
  output logic [15:0]                year_o,
  output logic                       leap_o,
  output logic                       year_wrapped_o
);

  cda_pkg::cmd_t cmd;
  cda_pkg::sts_t sts;

  cda_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i    (kind_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cda_dp #(
    .COUNT_BITS(COUNT_BITS),
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (kind_i),
    .count_i       (count_i),
    .load_day_i    (load_day_i),
    .load_month_i  (load_month_i),
    .load_year_i   (load_year_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .day_o         (day_o),
    .month_o       (month_o),
    .year_o        (year_o),
    .leap_o        (leap_o),
    .year_wrapped_o(year_wrapped_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cda_ctrl.sv
// Controller state machine that sequences load, divide, year bump, month walk and clamp.
`timescale 1ns / 1ps
`default_nettype none

module cda_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    kind_i,
  input  wire cda_pkg::sts_t sts_i,
  output cda_pkg::cmd_t      cmd_o
);

  cda_pkg::state_e state_q, state_d;
  cda_pkg::kind_e  mode_q, mode_d;

  cda_pkg::kind_e kind_in;

  assign kind_in = cda_pkg::kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cda_pkg::ST_IDLE;
      mode_q  <= cda_pkg::KIND_NONE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      cda_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = kind_in;
          if (kind_in == cda_pkg::KIND_DAYS || kind_in == cda_pkg::KIND_MONTHS) begin
            state_d = cda_pkg::ST_DIV;
          end else begin
            state_d = cda_pkg::ST_DONE;
          end
        end
      end
      cda_pkg::ST_DIV: begin
        state_d = cda_pkg::ST_BUMP;
      end
      cda_pkg::ST_BUMP: begin
        if (mode_q == cda_pkg::KIND_MONTHS) begin
          state_d = cda_pkg::ST_CLAMP;
        end else begin
          state_d = cda_pkg::ST_WALK;
        end
      end
      cda_pkg::ST_WALK: begin
        if (sts_i.walk_fits) begin
          state_d = cda_pkg::ST_DONE;
        end
      end
      cda_pkg::ST_CLAMP: begin
        state_d = cda_pkg::ST_DONE;
      end
      cda_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = cda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cda_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cda_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.load   = in_valid_i && (kind_in == cda_pkg::KIND_LOAD);
        cmd_o.start  = in_valid_i &&
                       (kind_in == cda_pkg::KIND_DAYS || kind_in == cda_pkg::KIND_MONTHS);
      end
      cda_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      cda_pkg::ST_BUMP: begin
        cmd_o.bump = 1'b1;
      end
      cda_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      cda_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
      end
      cda_pkg::ST_DONE: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cda_dp.sv
// Datapath: date registers, reciprocal divider, year adder, month walker and result register.
`timescale 1ns / 1ps
`default_nettype none

module cda_dp #(
  parameter int COUNT_BITS = cda_pkg::DEF_COUNT_BITS,
  parameter int YEAR_BITS  = cda_pkg::DEF_YEAR_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cda_pkg::cmd_t         cmd_i,
  output cda_pkg::sts_t              sts_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [COUNT_BITS-1:0] count_i,
  input  wire logic [4:0]            load_day_i,
  input  wire logic [3:0]            load_month_i,
  input  wire logic [15:0]           load_year_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [4:0]                 day_o,
  output logic [3:0]                 month_o,
  output logic [15:0]                year_o,
  output logic                       leap_o,
  output logic                       year_wrapped_o
);

  localparam int DIV_W  = COUNT_BITS + 1;
  localparam int MUL_W  = DIV_W + 1;
  localparam int PROD_W = DIV_W + MUL_W;
  localparam int SH_DAY = DIV_W + 11;
  localparam int SH_MON = DIV_W + 4;
  localparam int REM_W  = DIV_W + 12;
  localparam int INC_W  = DIV_W + 2;
  localparam int SUM_W  = ((YEAR_BITS > INC_W) ? YEAR_BITS : INC_W) + 1;

  // Reciprocals rounded up; the rounding error times any DIV_W-bit dividend stays
  // below one unit of the shift, so the quotient is exact.
  localparam logic [63:0] RCP_DAY_L = ((64'd1 << SH_DAY) + 64'(cda_pkg::DAYS_PER_QUAD)
                                       - 64'd1) / 64'(cda_pkg::DAYS_PER_QUAD);
  localparam logic [63:0] RCP_MON_L = ((64'd1 << SH_MON) + 64'(cda_pkg::MONTHS_PER_YEAR)
                                       - 64'd1) / 64'(cda_pkg::MONTHS_PER_YEAR);
  localparam logic [MUL_W-1:0] RCP_DAY = RCP_DAY_L[MUL_W-1:0];
  localparam logic [MUL_W-1:0] RCP_MON = RCP_MON_L[MUL_W-1:0];

  // Date state.
  logic [4:0]           day_q, day_d;
  logic [3:0]           month_q, month_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic                 wrap_q, wrap_d;

  // Divider: dvd_q holds the dividend, quo_q the quotient, rem_q the days left to walk.
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [10:0]      rem_q, rem_d;
  logic             months_q, months_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_day_q, out_day_d;
  logic [3:0]  out_month_q, out_month_d;
  logic [15:0] out_year_q, out_year_d;
  logic        out_leap_q, out_leap_d;
  logic        out_wrap_q, out_wrap_d;

  logic [31:0]          reset_year_ext;
  logic [31:0]          load_year_ext;
  logic [31:0]          year_ext;
  logic [YEAR_BITS-1:0] load_year;
  logic [3:0]           load_month;
  logic [4:0]           load_len;
  logic [4:0]           cur_len;
  logic [11:0]          divisor;
  logic [MUL_W-1:0]     rcp;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    prod_shr;
  logic [REM_W-1:0]     quo_times;
  logic [REM_W-1:0]     rem_full;
  logic [INC_W-1:0]     inc;
  logic [SUM_W-1:0]     year_sum;
  logic [11:0]          day_plus;
  logic                 fits;

  assign reset_year_ext = 32'(cda_pkg::RESET_YEAR);
  assign load_year_ext  = 32'(load_year_i);
  assign year_ext       = 32'(year_q);
  assign load_year      = load_year_ext[YEAR_BITS-1:0];
  assign load_month     = (load_month_i > cda_pkg::MONTH_DEC) ? cda_pkg::MONTH_DEC : load_month_i;
  assign load_len       = cda_pkg::month_length(load_month, load_year[1:0] == 2'b00);
  assign cur_len        = cda_pkg::month_length(month_q, year_q[1:0] == 2'b00);

  assign divisor  = months_q ? cda_pkg::MONTHS_PER_YEAR : cda_pkg::DAYS_PER_QUAD;
  assign rcp      = months_q ? RCP_MON : RCP_DAY;
  assign prod     = PROD_W'(dvd_q) * PROD_W'(rcp);
  assign prod_shr = months_q ? (prod >> SH_MON) : (prod >> SH_DAY);

  assign quo_times = REM_W'(quo_q) * REM_W'(divisor);
  assign rem_full  = REM_W'(dvd_q) - quo_times;

  // Months carry the whole quotient into the year; days carry four years per quotient unit.
  assign inc      = months_q ? INC_W'(quo_q) : {quo_q, 2'b00};
  assign year_sum = SUM_W'(year_q) + SUM_W'(inc);

  assign day_plus = 12'(day_q) + 12'(rem_q);
  assign fits     = (day_plus <= 12'(cur_len));

  assign sts_o.walk_fits = fits;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    wrap_d   = wrap_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    months_d = months_q;

    if (cmd_i.accept) begin
      wrap_d = 1'b0;
    end

    if (cmd_i.load) begin
      month_d = load_month;
      year_d  = load_year;
      day_d   = cda_pkg::clamp_day(load_day_i, load_len);
    end

    if (cmd_i.start) begin
      months_d = (cda_pkg::kind_e'(kind_i) == cda_pkg::KIND_MONTHS);
      if (cda_pkg::kind_e'(kind_i) == cda_pkg::KIND_MONTHS) begin
        dvd_d = DIV_W'(month_q) + DIV_W'(count_i);
      end else begin
        dvd_d = DIV_W'(count_i);
      end
    end

    if (cmd_i.div_step) begin
      quo_d = prod_shr[DIV_W-1:0];
    end

    if (cmd_i.bump) begin
      year_d = year_sum[YEAR_BITS-1:0];
      wrap_d = wrap_q | (|year_sum[SUM_W-1:YEAR_BITS]);
      rem_d  = rem_full[10:0];
      if (months_q) begin
        month_d = rem_full[3:0];
      end
    end

    // One month per cycle; rem_q holds the days still to add.
    if (cmd_i.walk) begin
      if (fits) begin
        day_d = day_plus[4:0];
      end else begin
        rem_d = rem_q - (11'(cur_len) - 11'(day_q) + 11'd1);
        day_d = cda_pkg::FIRST_DAY;
        if (month_q >= cda_pkg::MONTH_DEC) begin
          month_d = cda_pkg::MONTH_JAN;
          year_d  = year_q + YEAR_BITS'(1);
          wrap_d  = wrap_q | (&year_q);
        end else begin
          month_d = month_q + 4'd1;
        end
      end
    end

    if (cmd_i.clamp) begin
      day_d = cda_pkg::clamp_day(day_q, cur_len);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_day_d   = out_day_q;
    out_month_d = out_month_q;
    out_year_d  = out_year_q;
    out_leap_d  = out_leap_q;
    out_wrap_d  = out_wrap_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_day_d   = day_q;
      out_month_d = month_q;
      out_year_d  = year_ext[15:0];
      out_leap_d  = (year_q[1:0] == 2'b00);
      out_wrap_d  = wrap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q       <= cda_pkg::FIRST_DAY;
      month_q     <= cda_pkg::MONTH_JAN;
      year_q      <= reset_year_ext[YEAR_BITS-1:0];
      wrap_q      <= 1'b0;
      months_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      wrap_q      <= wrap_d;
      months_q    <= months_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    out_day_q   <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q  <= out_year_d;
    out_leap_q  <= out_leap_d;
    out_wrap_q  <= out_wrap_d;
  end

  assign out_valid_o    = out_valid_q;
  assign day_o          = out_day_q;
  assign month_o        = out_month_q;
  assign year_o         = out_year_q;
  assign leap_o         = out_leap_q;
  assign year_wrapped_o = out_wrap_q;

endmodule

`default_nettype wire
